// File: hw/rtl/mac_pkg.sv
package mac_pkg;

    // field widths fixed by the stream format
    localparam int IN_PRICE_BITS  = 32;
    localparam int STAMP_BITS     = 64;
    localparam int LEN_BITS       = 9;
    localparam int CFG_INDEX_BITS = 2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHORT_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_LENGTH  = 2'd1;

    // register reset values
    localparam logic [LEN_BITS-1:0] RESET_SHORT_LENGTH = 9'd10;
    localparam logic [LEN_BITS-1:0] RESET_LONG_LENGTH  = 9'd50;

    // signal codes
    localparam logic [1:0] SIG_HOLD = 2'd0;
    localparam logic [1:0] SIG_BUY  = 2'd1;
    localparam logic [1:0] SIG_SELL = 2'd2;

    // strength in halves
    localparam logic [1:0] STR_WARM = 2'd0;
    localparam logic [1:0] STR_HALF = 2'd1;
    localparam logic [1:0] STR_FULL = 2'd2;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;

    // item tag that rides along the compare pipeline
    typedef struct packed {
        logic                  valid;
        logic                  live;
        logic [STAMP_BITS-1:0] stamp;
    } mac_tag_t;

    // one result word, signal in the lowest bits
    typedef struct packed {
        logic [STAMP_BITS-1:0] stamp;
        logic [1:0]            strength;
        logic [1:0]            sig;
    } mac_result_t;

endpackage

// File: hw/rtl/mac_ring.sv
module mac_ring #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_a_reg;
    logic [DW-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-through: a read of the slot being written returns the new price
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
        rdata_b_reg <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: hw/rtl/mac_cmp.sv
module mac_cmp #(
    parameter int SW = 41,
    parameter int NW = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mac_pkg::mac_tag_t    tag,
    input  logic [SW-1:0]        short_total,
    input  logic [SW-1:0]        long_total,
    input  logic [NW-1:0]        long_len,
    input  logic [NW-1:0]        short_cnt,
    output logic                 res_valid,
    output mac_pkg::mac_result_t result
);

    localparam int PW = SW + NW;

    logic [PW-1:0]     prod_s_reg;
    logic [PW-1:0]     prod_l_reg;
    mac_pkg::mac_tag_t tag_reg;

    // cross products: short sum by long length, long sum by short count
    always_ff @(posedge clk)
    begin
        prod_s_reg <= PW'(short_total) * PW'(long_len);
        prod_l_reg <= PW'(long_total) * PW'(short_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    always_comb
    begin
        result.stamp = tag_reg.stamp;
        if (!tag_reg.live)
        begin
            result.sig      = mac_pkg::SIG_HOLD;
            result.strength = mac_pkg::STR_WARM;
        end
        else if (prod_s_reg > prod_l_reg)
        begin
            result.sig      = mac_pkg::SIG_BUY;
            result.strength = mac_pkg::STR_FULL;
        end
        else if (prod_s_reg < prod_l_reg)
        begin
            result.sig      = mac_pkg::SIG_SELL;
            result.strength = mac_pkg::STR_FULL;
        end
        else
        begin
            result.sig      = mac_pkg::SIG_HOLD;
            result.strength = mac_pkg::STR_HALF;
        end
    end

    assign res_valid = tag_reg.valid;

endmodule

// File: hw/rtl/mac_fifo.sv
module mac_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  mac_pkg::mac_result_t       push_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output mac_pkg::mac_result_t       out_data,
    output logic [mac_pkg::FIFO_AW:0]  count
);

    mac_pkg::mac_result_t            buf_mem [mac_pkg::FIFO_DEPTH];
    logic [mac_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [mac_pkg::FIFO_AW-1:0]     wr_ptr_next;
    logic [mac_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [mac_pkg::FIFO_AW-1:0]     rd_ptr_next;
    logic [mac_pkg::FIFO_AW:0]       count_reg;
    logic [mac_pkg::FIFO_AW:0]       count_next;
    logic                            pop;

    assign pop = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{mac_pkg::FIFO_AW{1'b0}}, push}
                                - {{mac_pkg::FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_data  = buf_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// File: hw/rtl/moving_average_crossover.sv
// channel   dir  word                                        handshake
// s_*       in   price [31:0], stamp [95:32]                 tvalid/tready
// m_*       out  signal [1:0], strength [3:2], stamp [67:4]  tvalid/tready
// cfg_*     in   index 0 short_length, 1 long_length         cfg_we, no wait
//
// one word per cycle sustained while s_tready stays high; a taken word passes through
// ring read, sum update, cross multiply and compare into the output queue
// rst_n clears pointers, counts, sums and the queue; the ring needs no clearing
// since only slots written since the last history clear are ever read
// results sit in an 8-word queue; s_tready drops when queue plus in-flight words
// reach 8, so a stalled master stops the input before the queue itself is full
module moving_average_crossover #(
    parameter int MAX_WINDOW = 256,
    parameter int PRICE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // price [31:0], stamp [95:32]
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // signal [1:0], strength_halves [3:2], stamp_out [67:4]
    // configuration
    input  logic        cfg_we,
    input  logic [mac_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mac_pkg::LEN_BITS-1:0]       cfg_data
);

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int AW1 = AW + 1;
    localparam int NW  = (AW1 > mac_pkg::LEN_BITS) ? AW1 : mac_pkg::LEN_BITS;
    localparam int SW  = PRICE_BITS + AW + 1;
    localparam int XW  = (PRICE_BITS > mac_pkg::IN_PRICE_BITS) ? PRICE_BITS
                                                               : mac_pkg::IN_PRICE_BITS;
    localparam logic [AW-1:0]         LAST_SLOT = AW'(MAX_WINDOW - 1);
    localparam logic [AW1-1:0]        DEPTH_W   = AW1'(MAX_WINDOW);
    localparam logic [NW-1:0]         MAX_LEN   = NW'(MAX_WINDOW);
    localparam logic [NW-1:0]         ONE_LEN   = NW'(1);
    localparam logic [PRICE_BITS-1:0] PMAX      = '1;

    // length clamp: zero counts as one, beyond the ring counts as the ring
    function automatic logic [NW-1:0] clamp_len(input logic [mac_pkg::LEN_BITS-1:0] v);
        logic [NW-1:0] e;
        e = NW'(v);
        if (e == '0)
        begin
            return ONE_LEN;
        end
        else if (e > MAX_LEN)
        begin
            return MAX_LEN;
        end
        return e;
    endfunction

    // slot that leaves a window of len samples, modulo the ring depth
    function automatic logic [AW-1:0] leave_slot(input logic [AW-1:0] slot,
                                                 input logic [NW-1:0] len);
        logic [AW1-1:0] sum;
        sum = AW1'(slot) + (DEPTH_W - len[AW1-1:0]);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    // configuration
    logic [mac_pkg::LEN_BITS-1:0] short_len_reg;
    logic [mac_pkg::LEN_BITS-1:0] long_len_reg;
    logic                         cfg_hit;
    logic [NW-1:0]                s_len;
    logic [NW-1:0]                l_len;

    // front end state, advanced at accept
    logic                  accept;
    logic [AW-1:0]         slot_reg;
    logic [AW-1:0]         slot_next;
    logic [NW-1:0]         seen_reg;
    logic [NW-1:0]         seen_next;
    logic [XW-1:0]         price_ext;
    logic [PRICE_BITS-1:0] price_sat;
    logic [AW-1:0]         raddr_s;
    logic [AW-1:0]         raddr_l;

    // stage 1: ring read in flight
    logic                           v1_reg;
    logic [PRICE_BITS-1:0]          price1_reg;
    logic [mac_pkg::STAMP_BITS-1:0] stamp1_reg;
    logic [AW-1:0]                  slot1_reg;
    logic                           sub_s1_reg;
    logic                           sub_l1_reg;
    logic                           live1_reg;
    logic [NW-1:0]                  s_cnt1_reg;
    logic [NW-1:0]                  l_len1_reg;
    logic [PRICE_BITS-1:0]          leave_s;
    logic [PRICE_BITS-1:0]          leave_l;

    // stage 2: running sums
    logic [SW-1:0]     short_total_reg;
    logic [SW-1:0]     short_total_next;
    logic [SW-1:0]     long_total_reg;
    logic [SW-1:0]     long_total_next;
    mac_pkg::mac_tag_t tag2_reg;
    logic [NW-1:0]     s_cnt2_reg;
    logic [NW-1:0]     l_len2_reg;

    // compare and queue
    logic                      v3;
    mac_pkg::mac_result_t      cmp_result;
    mac_pkg::mac_result_t      fifo_out;
    logic [mac_pkg::FIFO_AW:0] fifo_count;
    logic [mac_pkg::FIFO_AW:0] occupancy;

    assign cfg_hit = cfg_we && ((cfg_index == mac_pkg::CFG_SHORT_LENGTH)
                             || (cfg_index == mac_pkg::CFG_LONG_LENGTH));
    assign s_len   = clamp_len(short_len_reg);
    assign l_len   = clamp_len(long_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_len_reg <= mac_pkg::RESET_SHORT_LENGTH;
            long_len_reg  <= mac_pkg::RESET_LONG_LENGTH;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mac_pkg::CFG_SHORT_LENGTH)
            begin
                short_len_reg <= cfg_data;
            end
            else if (cfg_index == mac_pkg::CFG_LONG_LENGTH)
            begin
                long_len_reg <= cfg_data;
            end
        end
    end

    // words in flight plus queued results never pass the queue depth
    assign occupancy = fifo_count + {{mac_pkg::FIFO_AW{1'b0}}, v1_reg}
                                  + {{mac_pkg::FIFO_AW{1'b0}}, tag2_reg.valid}
                                  + {{mac_pkg::FIFO_AW{1'b0}}, v3};
    assign s_tready  = (occupancy < (mac_pkg::FIFO_AW + 1)'(mac_pkg::FIFO_DEPTH));
    assign accept    = s_tvalid && s_tready;

    // price saturates to the configured tick width
    always_comb
    begin
        price_ext = XW'(s_tdata[mac_pkg::IN_PRICE_BITS-1:0]);
        price_sat = (price_ext > XW'(PMAX)) ? PMAX : price_ext[PRICE_BITS-1:0];
        slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
        seen_next = (seen_reg < MAX_LEN) ? seen_reg + 1'b1 : MAX_LEN;
        raddr_s   = leave_slot(slot_reg, s_len);
        raddr_l   = leave_slot(slot_reg, l_len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            seen_reg <= '0;
        end
        else if (cfg_hit)
        begin
            slot_reg <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            slot_reg <= slot_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        price1_reg <= price_sat;
        stamp1_reg <= s_tdata[95:32];
        slot1_reg  <= slot_reg;
        sub_s1_reg <= (seen_reg >= s_len);
        sub_l1_reg <= (seen_reg >= l_len);
        live1_reg  <= (seen_next >= l_len);
        s_cnt1_reg <= (s_len < seen_next) ? s_len : seen_next;
        l_len1_reg <= l_len;
    end

    // ring written in the cycle after accept, from stage 1; same-slot reads are forwarded inside
    mac_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW),
        .DW    (PRICE_BITS)
    ) u_ring (
        .clk     (clk),
        .we      (v1_reg),
        .waddr   (slot1_reg),
        .wdata   (price1_reg),
        .raddr_a (raddr_s),
        .raddr_b (raddr_l),
        .rdata_a (leave_s),
        .rdata_b (leave_l)
    );

    // sums drop the leaving sample once the window is full, then add the new one
    always_comb
    begin
        short_total_next = short_total_reg
                         - (sub_s1_reg ? SW'(leave_s) : '0)
                         + SW'(price1_reg);
        long_total_next  = long_total_reg
                         - (sub_l1_reg ? SW'(leave_l) : '0)
                         + SW'(price1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_total_reg <= '0;
            long_total_reg  <= '0;
            tag2_reg        <= '0;
        end
        else
        begin
            tag2_reg.valid <= v1_reg;
            tag2_reg.live  <= live1_reg;
            tag2_reg.stamp <= stamp1_reg;
            if (cfg_hit)
            begin
                short_total_reg <= '0;
                long_total_reg  <= '0;
            end
            else if (v1_reg)
            begin
                short_total_reg <= short_total_next;
                long_total_reg  <= long_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_cnt2_reg <= s_cnt1_reg;
        l_len2_reg <= l_len1_reg;
    end

    mac_cmp #(
        .SW (SW),
        .NW (NW)
    ) u_cmp (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (tag2_reg),
        .short_total (short_total_reg),
        .long_total  (long_total_reg),
        .long_len    (l_len2_reg),
        .short_cnt   (s_cnt2_reg),
        .res_valid   (v3),
        .result      (cmp_result)
    );

    mac_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (v3),
        .push_data (cmp_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_out),
        .count     (fifo_count)
    );

    assign m_tdata = {4'b0000, fifo_out};

    // queue never overflows: credit covers every word in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (mac_pkg::FIFO_AW + 1)'(mac_pkg::FIFO_DEPTH))
        else $error("output queue overcommitted");

    // an accepted word is in stage 1 on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted word lost before ring read");

    // hold goes with strength below full, buy or sell with full strength
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[1:0] == mac_pkg::SIG_HOLD) == (m_tdata[3:2] != mac_pkg::STR_FULL)))
        else $error("signal and strength disagree");

    // sample count saturates at the ring depth
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= MAX_LEN)
        else $error("sample count beyond ring depth");

endmodule
